// ===== rtl/core/qdsm_pkg.sv =====
// Shared types, constants and tables for the quadrature decoder speed meter.
package qdsm_pkg;

   localparam int CHANNELS         = 2;
   localparam int AVG_DEPTH        = 4;
   localparam int CH_W             = 1;
   localparam int SLOT_W           = $clog2(AVG_DEPTH);
   localparam int FILL_W           = $clog2(AVG_DEPTH + 1);
   localparam int RING_DEPTH       = CHANNELS * AVG_DEPTH;
   localparam int RING_AW          = CH_W + SLOT_W;
   localparam int TOTAL_W          = 34;
   localparam int DVD_W            = 42;
   localparam int DVS_W            = 32;
   localparam int DCNT_W           = $clog2(DVD_W + 1);
   localparam int SPEED_SCALE      = 1000;
   localparam int DEFAULT_INTERVAL = 10;
   localparam int CSR_AW           = 1;
   localparam int CSR_DW           = 16;

   typedef enum logic [1:0] {
      KIND_EDGE    = 2'd0,
      KIND_TICK    = 2'd1,
      KIND_CLEAR   = 2'd2,
      KIND_CAPTURE = 2'd3
   } kind_type;

   localparam logic [CSR_AW-1:0] CSR_INVERT   = 1'd0;
   localparam logic [CSR_AW-1:0] CSR_INTERVAL = 1'd1;

   typedef struct packed {
      logic [31:0]               pos;
      logic [31:0]               edges;
      logic [31:0]               invalid;
      logic [1:0]                prev;
      logic [31:0]               sampled;
      logic [31:0]               delta;
      logic [31:0]               avg;
      logic [TOTAL_W-1:0]        total;
      logic [SLOT_W-1:0]         slot;
      logic [FILL_W-1:0]         fill;
      logic [1:0]                dir;
   } chan_rec_type;

   localparam int REC_W = $bits(chan_rec_type);

   // Step indexed by {previous levels, new levels}.
   localparam logic [1:0] QUAD_STEP [16] = '{
      2'b00, 2'b11, 2'b01, 2'b00,
      2'b01, 2'b00, 2'b00, 2'b11,
      2'b11, 2'b00, 2'b00, 2'b01,
      2'b00, 2'b01, 2'b11, 2'b00
   };

   typedef struct packed {
      logic              start;
      logic [DVD_W-1:0]  dividend;
      logic [DVS_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DVD_W-1:0]  quotient;
   } div_rsp_type;

endpackage

// ===== rtl/core/quadrature_decoder_speed_meter.sv =====
// Two-channel quadrature decoder with sampled, averaged speed per channel.
// Edge, clear and capture items give one result each. A tick whose interval
// has elapsed gives one result per channel: the per-channel record is read
// from a RAM with registered read data, the position change is multiplied by
// 1000, then two passes (load, 42 quotient bits, finish) through one shared
// bit-serial divider (raw speed, then the running mean) give the speed. A
// tick before the interval has elapsed is taken and gives nothing. One item
// is in work at a time; a new item is taken while the last result still
// waits in the output register.
module quadrature_decoder_speed_meter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [39:0]                   req_tdata,  // channel, levels, now_ms
   input  logic [1:0]                    req_tuser,  // kind
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // channel_res, position, edges, invalid_count, delta, speed, direction
   output logic [167:0]                  rsp_tdata,
   output logic                          rsp_tuser,  // from_sample
   output logic                          rsp_tlast,
   input  logic                          csr_we,
   input  logic [qdsm_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [qdsm_pkg::CSR_DW-1:0]   csr_wdata
);
   import qdsm_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_READ  = 8'b0000_0010,
      S_EXEC  = 8'b0000_0100,
      S_MUL   = 8'b0000_1000,
      S_DIVR  = 8'b0001_0000,
      S_DIVA  = 8'b0010_0000,
      S_WRITE = 8'b0100_0000,
      S_EMIT  = 8'b1000_0000
   } state_type;

   state_type           state_ff;
   logic [CHANNELS-1:0] invert_ff;
   logic [15:0]         interval_ff;
   logic [31:0]         time_base_ff;
   logic [CHANNELS-1:0] rec_valid_ff;

   kind_type            kind_ff;
   logic [CH_W-1:0]     ch_ff;
   logic [1:0]          lv_ff;
   logic [31:0]         now_ff;
   logic [31:0]         elapsed_ff;
   chan_rec_type        rec_ff;
   logic [31:0]         ring_old_ff;
   logic [RING_AW-1:0]  ring_waddr_ff;
   logic [31:0]         raw_ff;
   logic                neg_ff;
   logic                tot_neg_ff;
   logic                div_start_ff;
   logic [DVD_W-1:0]    div_dvd_ff;
   logic [DVS_W-1:0]    div_dvs_ff;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   logic                rsp_valid_ff;
   logic [167:0]        rsp_data_ff;
   logic                rsp_user_ff;
   logic                rsp_last_ff;

   // input unpack
   logic [CH_W-1:0]     req_chan;
   logic [1:0]          req_lv;
   logic [31:0]         req_now;
   kind_type            req_kind;
   logic [31:0]         req_elapsed;
   logic [15:0]         iv;

   assign req_chan    = req_tdata[0];
   assign req_lv      = req_tdata[2:1];
   assign req_now     = req_tdata[34:3];
   assign req_kind    = kind_type'(req_tuser);
   assign req_elapsed = req_now - time_base_ff;
   assign iv          = (interval_ff == 16'd0) ? 16'd1 : interval_ff;

   assign div_req = {div_start_ff, div_dvd_ff, div_dvs_ff};

   // memories
   logic [REC_W-1:0]    rec_rdata;
   logic [31:0]         ring_rdata;
   logic                ring_we;
   logic [RING_AW-1:0]  ring_raddr;
   chan_rec_type        rec_rd;

   assign rec_rd     = rec_valid_ff[ch_ff] ? chan_rec_type'(rec_rdata) : '0;
   assign ring_raddr = {ch_ff, rec_rd.slot};
   assign ring_we    = (state_ff == S_WRITE) && (kind_ff == KIND_TICK);

   qdsm_ram #(.WIDTH(REC_W), .DEPTH(CHANNELS)) u_rec_ram (
      .clock (clock),
      .we    (state_ff == S_WRITE),
      .waddr (ch_ff),
      .wdata (REC_W'(rec_ff)),
      .raddr (ch_ff),
      .rdata (rec_rdata)
   );

   qdsm_ram #(.WIDTH(32), .DEPTH(RING_DEPTH)) u_ring_ram (
      .clock (clock),
      .we    (ring_we),
      .waddr (ring_waddr_ff),
      .wdata (raw_ff),
      .raddr (ring_raddr),
      .rdata (ring_rdata)
   );

   qdsm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // edge, clear and capture update
   chan_rec_type        rec_upd;
   logic [1:0]          st;
   logic [31:0]         step32;

   always_comb begin
      rec_upd = rec_rd;
      st      = QUAD_STEP[{rec_rd.prev, lv_ff}];
      step32  = {{30{st[1]}}, st};
      if (invert_ff[ch_ff]) begin
         step32 = -step32;
      end
      unique case (kind_ff)
         KIND_EDGE: begin
            rec_upd.edges = rec_rd.edges + 32'd1;
            rec_upd.prev  = lv_ff;
            if ((rec_rd.prev ^ lv_ff) == 2'b11) begin
               rec_upd.invalid = rec_rd.invalid + 32'd1;
            end else begin
               rec_upd.pos = rec_rd.pos + step32;
            end
         end
         KIND_CLEAR: begin
            rec_upd      = '0;
            rec_upd.prev = lv_ff;
         end
         KIND_CAPTURE: rec_upd.prev = lv_ff;
         default:      rec_upd = rec_rd;
      endcase
   end

   // sample arithmetic
   logic [31:0]         d;
   logic signed [DVD_W-1:0] prod;
   logic [DVD_W-1:0]    prod_mag;
   logic [DVD_W-1:0]    q;
   logic [31:0]         raw;
   logic [31:0]         old_spd;
   logic [TOTAL_W-1:0]  total_new;
   logic [TOTAL_W-1:0]  tot_mag;
   logic [FILL_W-1:0]   fill_new;
   logic [SLOT_W-1:0]   slot_new;
   logic [1:0]          dir_new;

   always_comb begin
      d        = rec_ff.pos - rec_ff.sampled;
      prod     = $signed({{(DVD_W-32){d[31]}}, d}) * $signed(DVD_W'(SPEED_SCALE));
      prod_mag = prod[DVD_W-1] ? DVD_W'(-prod) : DVD_W'(prod);
      q        = div_rsp.quotient;
      if (!neg_ff) begin
         raw = (q > DVD_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
      end else begin
         raw = (q > DVD_W'(32'h8000_0000)) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
      end
      old_spd   = (rec_ff.fill == FILL_W'(AVG_DEPTH)) ? ring_old_ff : 32'd0;
      total_new = rec_ff.total - {{(TOTAL_W-32){old_spd[31]}}, old_spd}
                  + {{(TOTAL_W-32){raw[31]}}, raw};
      tot_mag   = total_new[TOTAL_W-1] ? (~total_new + 1'b1) : total_new;
      fill_new  = (rec_ff.fill < FILL_W'(AVG_DEPTH)) ? rec_ff.fill + 1'b1 : rec_ff.fill;
      slot_new  = (rec_ff.slot == SLOT_W'(AVG_DEPTH - 1)) ? '0 : rec_ff.slot + 1'b1;
      if (d == 32'd0) begin
         dir_new = 2'b00;
      end else if (d[31]) begin
         dir_new = 2'b11;
      end else begin
         dir_new = 2'b01;
      end
   end

   logic out_free;
   logic last_ch;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign last_ch  = (kind_ff != KIND_TICK) || (ch_ff == CH_W'(CHANNELS - 1));

   assign req_tready = (state_ff == S_IDLE);

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         invert_ff    <= '0;
         interval_ff  <= 16'(DEFAULT_INTERVAL);
         time_base_ff <= '0;
         rec_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         // launch the raw-speed divide, then the mean divide
         div_start_ff <= (state_ff == S_MUL) || ((state_ff == S_DIVR) && div_rsp.done);
         if (csr_we) begin
            case (csr_addr)
               CSR_INVERT:   invert_ff   <= csr_wdata[CHANNELS-1:0];
               CSR_INTERVAL: interval_ff <= csr_wdata;
               default:      interval_ff <= interval_ff;
            endcase
         end
         if (rsp_tready && !((state_ff == S_EMIT) && out_free)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  if (req_kind == KIND_TICK) begin
                     if (req_elapsed >= {16'd0, iv}) begin
                        state_ff <= S_READ;
                     end
                  end else if (32'(req_chan) < 32'(CHANNELS)) begin
                     state_ff <= S_READ;
                  end
               end
            end
            S_READ: state_ff <= S_EXEC;
            S_EXEC: state_ff <= (kind_ff == KIND_TICK) ? S_MUL : S_WRITE;
            S_MUL:  state_ff <= S_DIVR;
            S_DIVR: begin
               if (div_rsp.done) begin
                  state_ff <= S_DIVA;
               end
            end
            S_DIVA: begin
               if (div_rsp.done) begin
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               rec_valid_ff[ch_ff] <= 1'b1;
               if (kind_ff == KIND_CAPTURE) begin
                  time_base_ff <= now_ff;
               end
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (last_ch) begin
                     if (kind_ff == KIND_TICK) begin
                        time_base_ff <= now_ff;
                     end
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff <= S_READ;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // payload
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            kind_ff    <= req_kind;
            ch_ff      <= (req_kind == KIND_TICK) ? '0 : req_chan;
            lv_ff      <= req_lv;
            now_ff     <= req_now;
            elapsed_ff <= req_elapsed;
         end
         S_EXEC: begin
            rec_ff        <= (kind_ff == KIND_TICK) ? rec_rd : rec_upd;
            ring_waddr_ff <= ring_raddr;
         end
         S_MUL: begin
            ring_old_ff <= ring_rdata;
            neg_ff      <= prod[DVD_W-1];
            div_dvd_ff  <= prod_mag;
            div_dvs_ff  <= elapsed_ff;
         end
         S_DIVR: begin
            if (div_rsp.done) begin
               raw_ff         <= raw;
               rec_ff.sampled <= rec_ff.pos;
               rec_ff.delta   <= d;
               rec_ff.dir     <= dir_new;
               rec_ff.total   <= total_new;
               rec_ff.fill    <= fill_new;
               rec_ff.slot    <= slot_new;
               tot_neg_ff     <= total_new[TOTAL_W-1];
               div_dvd_ff     <= DVD_W'(tot_mag);
               div_dvs_ff     <= DVS_W'(fill_new);
            end
         end
         S_DIVA: begin
            if (div_rsp.done) begin
               rec_ff.avg <= tot_neg_ff ? (~q[31:0] + 32'd1) : q[31:0];
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_data_ff <= {5'd0, rec_ff.dir, rec_ff.avg, rec_ff.delta,
                               rec_ff.invalid, rec_ff.edges, rec_ff.pos, ch_ff};
               rsp_user_ff <= (kind_ff == KIND_TICK);
               rsp_last_ff <= last_ch;
               if (!last_ch) begin
                  ch_ff <= ch_ff + 1'b1;
               end
            end
         end
         default: ch_ff <= ch_ff;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !div_rsp.busy)
      else $error("divider busy while idle");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIVR || state_ff == S_DIVA))
      else $error("divider finished outside a divide step");

   a_item_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("non-sample result not marked last");

   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[162:161] != 2'b10))
      else $error("direction out of range");

endmodule

// ===== rtl/core/qdsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module qdsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/qdsm_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
module qdsm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  qdsm_pkg::div_req_type div_req,
   output qdsm_pkg::div_rsp_type div_rsp
);
   import qdsm_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic [DVS_W-1:0]  rem_ff;
   logic [DVD_W-1:0]  quo_ff;
   logic [DVS_W-1:0]  dvs_ff;

   logic [DVS_W:0]    rem_sh;
   logic              ge;
   logic [DVS_W-1:0]  rem_in;

   // remainder stays below the divisor, so it always fits DVS_W bits
   always_comb begin
      rem_sh = {rem_ff, quo_ff[DVD_W-1]};
      ge     = rem_sh >= {1'b0, dvs_ff};
      rem_in = ge ? DVS_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[DVS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DCNT_W'(DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DCNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.dividend;
         dvs_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DVD_W-2:0], ge};
      end
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== verif/qdsm_checker.sv =====
// Checker for the quadrature decoder speed meter: predicts each result and compares it.
`timescale 1ns / 1ps
module qdsm_checker
   import qdsm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [39:0]         req_tdata,  // channel, levels, now_ms
   input  logic [1:0]          req_tuser,  // kind
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   // channel_res, position, edges, invalid_count, delta, speed, direction
   input  logic [167:0]        rsp_tdata,
   input  logic                rsp_tuser,  // from_sample
   input  logic                rsp_tlast,
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_addr,
   input  logic [CSR_DW-1:0]   csr_wdata,
   output int                  fail_count,
   output int                  pending,
   output int                  result_count,
   output int                  sample_count
);

   typedef struct {
      bit        ch;
      bit [31:0] pos;
      bit [31:0] edges;
      bit [31:0] invalid;
      bit [31:0] delta;
      bit [31:0] speed;
      bit [1:0]  dir;
      bit        sampled;
      bit        fin;
   } speed_report_type;

   speed_report_type report_q[$];

   bit [1:0]  invert_bits;
   bit [15:0] interval_ms;
   bit [31:0] pos_cnt   [CHANNELS];
   bit [31:0] edge_cnt  [CHANNELS];
   bit [31:0] bad_cnt   [CHANNELS];
   bit [1:0]  last_lv   [CHANNELS];
   bit [31:0] pos_at_smp[CHANNELS];
   int        delta_val [CHANNELS];
   int        mean_speed[CHANNELS];
   int        hist      [CHANNELS][AVG_DEPTH];
   longint    hist_sum  [CHANNELS];
   int        hist_slot [CHANNELS];
   int        hist_fill [CHANNELS];
   int        dir_val   [CHANNELS];
   bit [31:0] base_ms;

   task automatic zero_channel(int c, bit [1:0] lv);
      pos_cnt[c]    = '0;
      edge_cnt[c]   = '0;
      bad_cnt[c]    = '0;
      last_lv[c]    = lv;
      pos_at_smp[c] = '0;
      delta_val[c]  = 0;
      mean_speed[c] = 0;
      for (int i = 0; i < AVG_DEPTH; i++) hist[c][i] = 0;
      hist_sum[c]   = 0;
      hist_slot[c]  = 0;
      hist_fill[c]  = 0;
      dir_val[c]    = 0;
   endtask

   // Position along the forward Gray cycle 00 -> 10 -> 11 -> 01.
   function automatic int gray_pos(bit [1:0] lv);
      case (lv)
         2'b00: return 0;
         2'b10: return 1;
         2'b11: return 2;
         default: return 3;
      endcase
   endfunction

   function automatic speed_report_type snapshot(int c, bit smp, bit fin);
      speed_report_type r;
      r.ch      = c[0];
      r.pos     = pos_cnt[c];
      r.edges   = edge_cnt[c];
      r.invalid = bad_cnt[c];
      r.delta   = delta_val[c];
      r.speed   = mean_speed[c];
      r.dir     = dir_val[c][1:0];
      r.sampled = smp;
      r.fin     = fin;
      return r;
   endfunction

   task automatic take_speed_sample(int c, bit [31:0] elapsed);
      int     d;
      longint raw;
      d   = int'(pos_cnt[c] - pos_at_smp[c]);
      raw = (longint'(d) * 1000) / longint'({32'b0, elapsed});
      if (raw > 64'sd2147483647) raw = 64'sd2147483647;
      if (raw < -64'sd2147483648) raw = -64'sd2147483648;
      pos_at_smp[c] = pos_cnt[c];
      delta_val[c]  = d;
      if (hist_fill[c] < AVG_DEPTH) hist_fill[c]++;
      else hist_sum[c] -= hist[c][hist_slot[c]];
      hist[c][hist_slot[c]] = int'(raw);
      hist_sum[c] += raw;
      hist_slot[c] = (hist_slot[c] + 1) % AVG_DEPTH;
      mean_speed[c] = int'(hist_sum[c] / longint'(hist_fill[c]));
      dir_val[c] = (d > 0) ? 1 : ((d < 0) ? -1 : 0);
   endtask

   task automatic predict_item(kind_type k, bit ch, bit [1:0] lv, bit [31:0] now);
      bit [31:0] elapsed;
      bit [31:0] min_gap;
      int        c;
      int        stp;
      c = ch;
      if (k == KIND_TICK) begin
         elapsed = now - base_ms;
         min_gap = (interval_ms == 0) ? 32'd1 : {16'b0, interval_ms};
         if (elapsed < min_gap) return;
         for (int i = 0; i < CHANNELS; i++) begin
            take_speed_sample(i, elapsed);
            report_q.push_back(snapshot(i, 1'b1, i == CHANNELS - 1));
         end
         base_ms = now;
         sample_count++;
         return;
      end
      case (k)
         KIND_EDGE: begin
            edge_cnt[c]++;
            if ((last_lv[c] ^ lv) == 2'b11) begin
               bad_cnt[c]++;
            end else begin
               if (last_lv[c] == lv) stp = 0;
               else stp = (((gray_pos(lv) - gray_pos(last_lv[c])) & 3) == 1) ? 1 : -1;
               if (invert_bits[c]) stp = -stp;
               pos_cnt[c] += stp;
            end
            last_lv[c] = lv;
         end
         KIND_CLEAR: zero_channel(c, lv);
         default: begin
            last_lv[c] = lv;
            base_ms    = now;
         end
      endcase
      report_q.push_back(snapshot(c, 1'b0, 1'b1));
   endtask

   task automatic flag_mismatch(string what, bit [31:0] got, bit [31:0] want);
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count   = 0;
      pending      = 0;
      result_count = 0;
      sample_count = 0;
   end

   always @(posedge clock) begin
      speed_report_type want;
      if (reset) begin
         invert_bits = '0;
         interval_ms = 16'(DEFAULT_INTERVAL);
         for (int i = 0; i < CHANNELS; i++) zero_channel(i, 2'b00);
         base_ms = '0;
         report_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (report_q.size() == 0) begin
               flag_mismatch("unexpected result", 32'd1, 32'd0);
            end else begin
               want = report_q.pop_front();
               if (rsp_tdata[0] != want.ch) flag_mismatch("channel", rsp_tdata[0], want.ch);
               if (rsp_tdata[32:1] != want.pos) flag_mismatch("position", rsp_tdata[32:1], want.pos);
               if (rsp_tdata[64:33] != want.edges)
                  flag_mismatch("edges", rsp_tdata[64:33], want.edges);
               if (rsp_tdata[96:65] != want.invalid)
                  flag_mismatch("invalid", rsp_tdata[96:65], want.invalid);
               if (rsp_tdata[128:97] != want.delta)
                  flag_mismatch("delta", rsp_tdata[128:97], want.delta);
               if (rsp_tdata[160:129] != want.speed)
                  flag_mismatch("speed", rsp_tdata[160:129], want.speed);
               if (rsp_tdata[162:161] != want.dir)
                  flag_mismatch("direction", rsp_tdata[162:161], want.dir);
               if (rsp_tuser != want.sampled) flag_mismatch("from_sample", rsp_tuser, want.sampled);
               if (rsp_tlast != want.fin) flag_mismatch("last", rsp_tlast, want.fin);
            end
         end
         if (csr_we) begin
            if (csr_addr == CSR_INVERT) invert_bits = csr_wdata[1:0];
            else if (csr_addr == CSR_INTERVAL) interval_ms = csr_wdata;
         end
         if (req_tvalid && req_tready)
            predict_item(kind_type'(req_tuser), req_tdata[0], req_tdata[2:1], req_tdata[34:3]);
      end
      pending = report_q.size();
   end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the quadrature decoder speed meter: stimulus, pacing and verdict.
`timescale 1ns / 1ps
module tb;
   import qdsm_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_WAIT  = 300;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [39:0]         req_tdata  = '0;  // channel, levels, now_ms
   logic [1:0]          req_tuser  = KIND_EDGE;  // kind
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [167:0]        rsp_tdata;  // channel_res, position, edges, invalid, delta, speed, dir
   logic                rsp_tuser;  // from_sample
   logic                rsp_tlast;
   logic                csr_we     = 1'b0;
   logic [CSR_AW-1:0]   csr_addr   = CSR_INVERT;
   logic [CSR_DW-1:0]   csr_wdata  = '0;

   int        fail_count, pending, result_count, sample_count;
   int        cycles = 0;
   int        item_count = 0;
   int        stall_left = 0;
   bit        quiet = 1'b0;
   bit [1:0]  pin_lv [CHANNELS];
   bit [31:0] clock_ms = '0;
   bit [15:0] cur_interval = 16'(DEFAULT_INTERVAL);

   always #1 clock = ~clock;

   quadrature_decoder_speed_meter u_dut (.*);

   qdsm_checker u_check (.*);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side back-pressure in short random bursts.
   always @(posedge clock) begin
      if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_item(kind_type k, bit ch, bit [1:0] lv, bit [31:0] now);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= {5'b0, now, lv, ch};
      do @(posedge clock); while (!req_tready);
      item_count++;
      if (k == KIND_CLEAR || k == KIND_CAPTURE || k == KIND_EDGE) pin_lv[ch] = lv;
      if (k == KIND_TICK || k == KIND_CAPTURE) clock_ms = now;
   endtask

   task automatic settle;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_AW-1:0] addr, logic [CSR_DW-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      if (addr == CSR_INTERVAL) cur_interval = val;
   endtask

   function automatic bit [1:0] step_lv(bit [1:0] lv, bit fwd);
      // forward Gray cycle 00 -> 10 -> 11 -> 01
      case (lv)
         2'b00: return fwd ? 2'b10 : 2'b01;
         2'b10: return fwd ? 2'b11 : 2'b00;
         2'b11: return fwd ? 2'b01 : 2'b10;
         default: return fwd ? 2'b00 : 2'b11;
      endcase
   endfunction

   task automatic random_items(int n);
      int        r;
      bit        ch;
      bit [31:0] now;
      bit        fwd [CHANNELS];
      for (int c = 0; c < CHANNELS; c++) fwd[c] = 1'($urandom_range(0, 1));
      for (int i = 0; i < n; i++) begin
         r   = $urandom_range(0, 99);
         ch  = 1'($urandom_range(0, 1));
         now = $urandom();
         if (r < 60) begin
            if ($urandom_range(0, 19) == 0) fwd[ch] = ~fwd[ch];
            send_item(KIND_EDGE, ch, step_lv(pin_lv[ch], fwd[ch]), now);
         end else if (r < 67) begin
            send_item(KIND_EDGE, ch, ($urandom_range(0, 1) ? pin_lv[ch] ^ 2'b11 : pin_lv[ch]), now);
         end else if (r < 86) begin
            if ($urandom_range(0, 19) == 0) send_item(KIND_TICK, ch, 2'($urandom()), now);
            else send_item(KIND_TICK, ch, 2'($urandom()),
                           clock_ms + $urandom_range(0, 2 * cur_interval + 1));
         end else if (r < 94) begin
            send_item(KIND_CAPTURE, ch, 2'($urandom()),
                      $urandom_range(0, 3) == 0 ? now : clock_ms + $urandom_range(0, 40));
         end else begin
            send_item(KIND_CLEAR, ch, 2'($urandom()), now);
         end
      end
   endtask

   initial begin
      pin_lv[0] = 2'b00;
      pin_lv[1] = 2'b00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every step direction, invalid and repeated levels, timestamp wrap.
      send_item(KIND_CAPTURE, 1'b0, 2'b00, 32'd0);
      send_item(KIND_EDGE, 1'b0, 2'b10, 32'hFFFF_FFFF);
      send_item(KIND_EDGE, 1'b0, 2'b11, 32'd0);
      send_item(KIND_EDGE, 1'b0, 2'b01, 32'd0);
      send_item(KIND_EDGE, 1'b0, 2'b00, 32'd0);
      send_item(KIND_EDGE, 1'b0, 2'b01, 32'd0);
      send_item(KIND_EDGE, 1'b0, 2'b01, 32'd0);
      send_item(KIND_EDGE, 1'b0, 2'b10, 32'd0);
      send_item(KIND_EDGE, 1'b1, 2'b11, 32'd0);
      send_item(KIND_EDGE, 1'b1, 2'b01, 32'd0);
      send_item(KIND_TICK, 1'b0, 2'b00, 32'd5);
      send_item(KIND_TICK, 1'b1, 2'b11, 32'd10);
      send_item(KIND_CLEAR, 1'b1, 2'b11, 32'hAAAA_5555);
      send_item(KIND_CAPTURE, 1'b1, 2'b10, 32'hFFFF_FFF0);
      send_item(KIND_EDGE, 1'b1, 2'b11, 32'd0);
      send_item(KIND_TICK, 1'b0, 2'b00, 32'd5);
      send_item(KIND_TICK, 1'b0, 2'b00, 32'hFFFF_FFFF);
      settle();

      write_csr(CSR_INVERT, 16'd3);
      write_csr(CSR_INTERVAL, 16'd1);
      send_item(KIND_EDGE, 1'b0, 2'b11, 32'd0);
      send_item(KIND_EDGE, 1'b0, 2'b01, 32'd0);
      send_item(KIND_TICK, 1'b0, 2'b00, 32'd0);
      send_item(KIND_TICK, 1'b0, 2'b00, 32'd1);
      random_items(150);
      settle();

      write_csr(CSR_INVERT, 16'd1);
      write_csr(CSR_INTERVAL, 16'd65535);
      random_items(150);
      settle();

      write_csr(CSR_INVERT, 16'd2);
      write_csr(CSR_INTERVAL, 16'd0);
      random_items(150);
      settle();

      write_csr(CSR_INVERT, 16'd0);
      write_csr(CSR_INTERVAL, 16'd7);
      random_items(150);
      settle();

      quiet = 1'b1;
      write_csr(CSR_INTERVAL, 16'd3);
      random_items(180);
      settle();

      $display("covered %0d items and %0d results, %0d speed samples,", item_count,
               result_count, sample_count);
      $display("invert masks 0..3 and sample intervals 0, 1, 3, 7, 10, 65535");
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/qdsm_pkg.sv
rtl/core/qdsm_ram.sv
rtl/core/qdsm_div.sv
rtl/core/quadrature_decoder_speed_meter.sv
verif/qdsm_checker.sv
verif/tb.sv
